// ===== rtl/stereo_state_variable_filter_top_assert.svh =====
// Assertion macros for the stereo state variable filter.
// Each assertion expands to nothing when SYNTHESIS is defined.
`ifndef STEREO_STATE_VARIABLE_FILTER_TOP_ASSERT_SVH
`define STEREO_STATE_VARIABLE_FILTER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define SVF_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("svf assertion failed");
`define SVF_ASSERT_MSG(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error(msg);
`else
`define SVF_ASSERT(lbl, clk, rstn, prop)
`define SVF_ASSERT_MSG(lbl, clk, rstn, prop, msg)
`endif
`endif

// ===== rtl/svf_pkg.sv =====
// Shared types, widths and micro-op table for the stereo state variable filter.
// No dependencies; used by svf_mul, svf_seq and the top level.
package svf_pkg;

	localparam int unsigned SampleW = 16;
	localparam int unsigned CoefW   = 16;
	localparam int unsigned StateW  = 24;
	localparam int unsigned ProdW   = CoefW + 1 + StateW;
	localparam int unsigned AccW    = ProdW + 2;
	localparam int unsigned SumW    = StateW + 4;
	localparam int unsigned IdxW    = 3;

	localparam logic [IdxW-1:0] RegFreq = 3'd0;
	localparam logic [IdxW-1:0] RegDamp = 3'd1;
	localparam logic [IdxW-1:0] RegLp   = 3'd2;
	localparam logic [IdxW-1:0] RegBp   = 3'd3;
	localparam logic [IdxW-1:0] RegHp   = 3'd4;

	localparam logic [2:0] LastStep = 3'd6;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_PUSH
	} state_t;

	typedef enum logic [2:0] {
		OPA_FREQ,
		OPA_DAMP,
		OPA_LP,
		OPA_BP,
		OPA_HP
	} opa_t;

	typedef enum logic [1:0] {
		OPB_BAND,
		OPB_HIGH,
		OPB_LOW
	} opb_t;

	typedef enum logic [2:0] {
		CMB_NONE,
		CMB_LOW,
		CMB_HIGH,
		CMB_BAND,
		CMB_ACC_FIRST,
		CMB_ACC,
		CMB_ACC_LAST
	} cmb_t;

	typedef struct packed {
		opa_t opa;
		opb_t opb;
		cmb_t cmb;
	} uop_t;

	typedef struct packed {
		uop_t uop;
		logic ch;
		logic push;
	} ctrl_t;

	// One channel pass: the multiplier works ahead of the combine, which uses the registered product of the step before.
	function automatic uop_t uop_at(logic [2:0] step);
		uop_t u;
		u = '{opa: OPA_FREQ, opb: OPB_BAND, cmb: CMB_NONE};
		case (step)
			3'd0: u = '{opa: OPA_FREQ, opb: OPB_BAND, cmb: CMB_NONE};
			3'd1: u = '{opa: OPA_DAMP, opb: OPB_BAND, cmb: CMB_LOW};
			3'd2: u = '{opa: OPA_LP,   opb: OPB_LOW,  cmb: CMB_HIGH};
			3'd3: u = '{opa: OPA_FREQ, opb: OPB_HIGH, cmb: CMB_ACC_FIRST};
			3'd4: u = '{opa: OPA_HP,   opb: OPB_HIGH, cmb: CMB_BAND};
			3'd5: u = '{opa: OPA_BP,   opb: OPB_BAND, cmb: CMB_ACC};
			3'd6: u = '{opa: OPA_FREQ, opb: OPB_BAND, cmb: CMB_ACC_LAST};
			default: u = '{opa: OPA_FREQ, opb: OPB_BAND, cmb: CMB_NONE};
		endcase
		return u;
	endfunction

endpackage

// ===== rtl/svf_mul.sv =====
// Shared multiplier: unsigned 16-bit coefficient times signed 24-bit value.
// Depends on svf_pkg for widths; the product is registered.
module svf_mul (
	input  logic                                clk,
	input  logic [svf_pkg::CoefW-1:0]           a,
	input  logic signed [svf_pkg::StateW-1:0]   b,
	output logic signed [svf_pkg::ProdW-1:0]    prod
);
	import svf_pkg::*;

	logic signed [ProdW-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= $signed({1'b0, a}) * b;
	end

	assign prod = prod_q;

endmodule

// ===== rtl/svf_seq.sv =====
// Sequencer: walks the micro-op table for the left then the right channel.
// Depends on svf_pkg for the state type, control struct and table.
module svf_seq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           out_free,
	output logic           in_stall,
	output svf_pkg::ctrl_t ctrl
);
	import svf_pkg::*;

	state_t     state_q;
	state_t     state_d;
	logic [2:0] step_q;
	logic       ch_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_RUN;
			end
			ST_RUN: begin
				if (step_q == LastStep && ch_q) state_d = ST_PUSH;
			end
			ST_PUSH: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= 3'd0;
			ch_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE) begin
				step_q <= 3'd0;
				ch_q   <= 1'b0;
			end else if (state_q == ST_RUN) begin
				if (step_q == LastStep) begin
					step_q <= 3'd0;
					ch_q   <= 1'b1;
				end else begin
					step_q <= step_q + 3'd1;
				end
			end
		end
	end

	always_comb begin
		in_stall     = 1'b1;
		ctrl.uop     = '{opa: OPA_FREQ, opb: OPB_BAND, cmb: CMB_NONE};
		ctrl.ch      = ch_q;
		ctrl.push    = 1'b0;
		unique case (state_q)
			ST_IDLE: in_stall = 1'b0;
			ST_RUN:  ctrl.uop = uop_at(step_q);
			ST_PUSH: ctrl.push = out_free;
			default: in_stall = 1'b1;
		endcase
	end

endmodule

// ===== rtl/stereo_state_variable_filter_top.sv =====
// Stereo Chamberlin state variable filter, Q1.15 in and out, Q9.15 state.
// New input is stalled while a sample pair is in work, up to its push; the single shared
// 17x24 multiplier does six products per channel, channels in turn.
// Reset clears filter state, coefficient registers and handshakes; no clearing pass.
`include "stereo_state_variable_filter_top_assert.svh"
module stereo_state_variable_filter_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [svf_pkg::SampleW-1:0]    left_in,
	input  logic signed [svf_pkg::SampleW-1:0]    right_in,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [svf_pkg::SampleW-1:0]    left_out,
	output logic signed [svf_pkg::SampleW-1:0]    right_out,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [svf_pkg::IdxW-1:0]              cfg_index,
	input  logic [svf_pkg::CoefW-1:0]             cfg_data
);
	import svf_pkg::*;

	function automatic logic [StateW-1:0] sat24(logic [SumW-1:0] v);
		logic [StateW-1:0] r;
		r = v[StateW-1:0];
		if (v[SumW-1] && v[SumW-2:StateW-1] != '1) r = {1'b1, {(StateW-1){1'b0}}};
		else if (!v[SumW-1] && v[SumW-2:StateW-1] != '0) r = {1'b0, {(StateW-1){1'b1}}};
		return r;
	endfunction

	function automatic logic [SampleW-1:0] sat16(logic [SumW-1:0] v);
		logic [SampleW-1:0] r;
		r = v[SampleW-1:0];
		if (v[SumW-1] && v[SumW-2:SampleW-1] != '1) r = {1'b1, {(SampleW-1){1'b0}}};
		else if (!v[SumW-1] && v[SumW-2:SampleW-1] != '0) r = {1'b0, {(SampleW-1){1'b1}}};
		return r;
	endfunction

	ctrl_t ctrl;
	logic  out_free;

	logic [CoefW-1:0] freq_q, damp_q, lp_q, bp_q, hp_q;
	logic [StateW-1:0] low_l_q, band_l_q, low_r_q, band_r_q;
	logic [StateW-1:0] high_q;
	logic [SampleW-1:0] x_l_q, x_r_q;
	logic [AccW-1:0] acc_q;
	logic [SampleW-1:0] res_l_q, res_r_q;
	logic [SampleW-1:0] left_out_q, right_out_q;
	logic out_valid_q;

	logic [CoefW-1:0] mul_a;
	logic signed [StateW-1:0] mul_b;
	logic signed [ProdW-1:0] prod;
	logic [StateW-1:0] low_cur, band_cur;
	logic [SampleW-1:0] x_cur;
	logic [ProdW-1:0] prod_sh14, prod_sh15;
	logic [SumW-1:0] low_sum, high_sum, band_sum;
	logic [AccW-1:0] acc_sum;
	logic [SumW-1:0] mix;

	assign out_free  = !out_valid_q || !out_stall;
	assign cfg_ready = 1'b1;

	svf_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.out_free (out_free),
		.in_stall (in_stall),
		.ctrl     (ctrl)
	);

	svf_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_q <= '0;
			damp_q <= '0;
			lp_q   <= '0;
			bp_q   <= '0;
			hp_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				RegFreq: freq_q <= cfg_data;
				RegDamp: damp_q <= cfg_data;
				RegLp:   lp_q   <= cfg_data;
				RegBp:   bp_q   <= cfg_data;
				RegHp:   hp_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign low_cur  = ctrl.ch ? low_r_q : low_l_q;
	assign band_cur = ctrl.ch ? band_r_q : band_l_q;
	assign x_cur    = ctrl.ch ? x_r_q : x_l_q;

	always_comb begin
		case (ctrl.uop.opa)
			OPA_FREQ: mul_a = freq_q;
			OPA_DAMP: mul_a = damp_q;
			OPA_LP:   mul_a = lp_q;
			OPA_BP:   mul_a = bp_q;
			OPA_HP:   mul_a = hp_q;
			default:  mul_a = freq_q;
		endcase
		case (ctrl.uop.opb)
			OPB_BAND: mul_b = $signed(band_cur);
			OPB_HIGH: mul_b = $signed(high_q);
			OPB_LOW:  mul_b = $signed(low_cur);
			default:  mul_b = $signed(band_cur);
		endcase
	end

	// Floor shifts of the product; the shifted values fit the sum width.
	assign prod_sh14 = prod >>> 14;
	assign prod_sh15 = prod >>> 15;

	assign low_sum  = {{(SumW-StateW){low_cur[StateW-1]}}, low_cur} + prod_sh14[SumW-1:0];
	assign high_sum = {{(SumW-SampleW){x_cur[SampleW-1]}}, x_cur}
		- {{(SumW-StateW){low_cur[StateW-1]}}, low_cur} - prod_sh15[SumW-1:0];
	assign band_sum = {{(SumW-StateW){band_cur[StateW-1]}}, band_cur} + prod_sh14[SumW-1:0];

	assign acc_sum = ((ctrl.uop.cmb == CMB_ACC_FIRST) ? {AccW{1'b0}} : acc_q)
		+ {{(AccW-ProdW){prod[ProdW-1]}}, prod};
	assign mix = acc_sum[SumW+14:15];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_l_q  <= '0;
			band_l_q <= '0;
			low_r_q  <= '0;
			band_r_q <= '0;
		end else begin
			case (ctrl.uop.cmb)
				CMB_LOW: begin
					if (ctrl.ch) low_r_q <= sat24(low_sum);
					else         low_l_q <= sat24(low_sum);
				end
				CMB_BAND: begin
					if (ctrl.ch) band_r_q <= sat24(band_sum);
					else         band_l_q <= sat24(band_sum);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			x_l_q <= left_in;
			x_r_q <= right_in;
		end
		case (ctrl.uop.cmb) inside
			CMB_HIGH: high_q <= sat24(high_sum);
			CMB_ACC_FIRST, CMB_ACC: acc_q <= acc_sum;
			CMB_ACC_LAST: begin
				if (ctrl.ch) res_r_q <= sat16(mix);
				else         res_l_q <= sat16(mix);
			end
			default: ;
		endcase
		if (ctrl.push) begin
			left_out_q  <= res_l_q;
			right_out_q <= res_r_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.push) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign left_out  = $signed(left_out_q);
	assign right_out = $signed(right_out_q);

	`SVF_ASSERT(a_accept_blocks, clk, arst_n, (in_valid && !in_stall) |=> in_stall)
	`SVF_ASSERT_MSG(a_valid_from_push, clk, arst_n,
		$rose(out_valid) |-> $past(ctrl.push), "result shown without a push")
	`SVF_ASSERT_MSG(a_no_overwrite, clk, arst_n,
		(out_valid && out_stall) |=> !$past(ctrl.push), "pending result overwritten")

endmodule
